[rtl/bgd_pkg.sv]
// Package with shared types, constants and helpers of the bilinear grid deposit block.
`default_nettype none
package bgd_pkg;

    localparam int MAX_CELLS  = 63;
    localparam int FRAC_BITS  = 16;
    localparam int ACC_WIDTH  = 40;
    localparam int OUT_W      = 40;
    localparam int CELL_W     = 6;
    localparam int POS_W      = FRAC_BITS + 1;
    localparam int ROW_W      = CELL_W + 1;
    localparam int NODE_COUNT = (MAX_CELLS + 1) * (MAX_CELLS + 1);
    localparam int ADDR_W     = $clog2(NODE_COUNT);
    localparam int W_W        = FRAC_BITS + 1;
    localparam int SCL_W      = POS_W + CELL_W;
    localparam int PROD_W     = 2 * POS_W;
    localparam int WORD_W     = ACC_WIDTH + 1;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = QPTR_W + 1;
    localparam int CFG_IDX_W  = 1;

    localparam logic [POS_W-1:0]     ONE_FX  = POS_W'(1) << FRAC_BITS;
    localparam logic [PROD_W-1:0]    HALF_FX = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic [ACC_WIDTH-1:0] ACC_MAX = {ACC_WIDTH{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_CELLS_X = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y = 1'd1;

    localparam logic OP_DEPOSIT = 1'b0;
    localparam logic OP_READ    = 1'b1;

    typedef struct packed {
        logic              op;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [ADDR_W-1:0] node_index;
    } bgd_req_t;

    typedef struct packed {
        logic [OUT_W-1:0] node_value;
        logic             saturated;
    } bgd_res_t;

    typedef struct packed {
        logic                      op;
        logic [ADDR_W-1:0]         node_index;
        logic [ADDR_W-1:0]         base;
        logic [ROW_W-1:0]          row;
        logic [3:0][W_W-1:0]       w;
    } bgd_ent_t;

    typedef struct packed {
        logic clearing;
    } bgd_stat_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_ADDR,
        B_UPD,
        B_RDW
    } bgd_state_t;

    function automatic logic [CELL_W-1:0] eff_cells(input logic [CELL_W-1:0] c);
        logic [CELL_W-1:0] r;
        r = c;
        if (c == '0)
            r = CELL_W'(1);
        else if (int'(c) > MAX_CELLS)
            r = CELL_W'(MAX_CELLS);
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/bilinear_grid_deposit.sv]
// Top level of the bilinear (cloud-in-cell) grid deposit block.
//
// The block keeps a square mesh of 40-bit saturating accumulators, one word
// per node, with a sticky saturation mark per node. Requests enter through a
// queue-like port: a request is taken at a clock edge where push is high and
// full is low. A deposit request spreads one point over the four corner nodes
// of its cell and returns nothing; a read request returns one node's value.
// Results leave through a second queue-like port: the result on res is valid
// while empty is low and is taken at an edge where pop is high.
// The front end locates the cell and forms the weights in two registered
// stages, and a four-entry queue then decouples it from the back end. The back
// end does a read-modify-write on the single mesh memory, an address state and
// an update state per corner, and a read passes through one read state before
// its result is registered on res. The back end takes no new request until it
// has finished all four corners of a deposit; that memory sets the rate.
// After reset the back end sweeps the mesh to zero, one node per cycle, over
// all 4096 nodes; full stays high during that sweep. If the receiver holds off
// pop, the one-deep result register stays full, reads wait in the queue, and
// full rises once the queue is committed. cells_x and cells_y are written
// through cfg_we/cfg_addr/cfg_data and should change only while idle.
`default_nettype none
module bilinear_grid_deposit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire bgd_pkg::bgd_req_t               req,
    output logic                                 empty,
    input  wire logic                            pop,
    output bgd_pkg::bgd_res_t                    res,
    input  wire logic                            cfg_we,
    input  wire logic [bgd_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [bgd_pkg::CELL_W-1:0]      cfg_data
);
    import bgd_pkg::*;

    logic [CELL_W-1:0] cells_x_reg, cells_y_reg;
    logic              front_ready, accept;
    logic              q_push, q_pop, q_nonempty;
    logic [QCNT_W-1:0] q_count;
    bgd_ent_t          q_in, q_head;
    bgd_stat_t         stat;

    // Configuration registers; an index beyond the list has no effect.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_x_reg <= CELL_W'(MAX_CELLS);
            cells_y_reg <= CELL_W'(MAX_CELLS);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_CELLS_X: cells_x_reg <= cfg_data;
                REG_CELLS_Y: cells_y_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // No request is taken while the mesh is being cleared.
    assign full   = stat.clearing || !front_ready;
    assign accept = push && !full;

    bgd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (req),
        .cells_x(cells_x_reg),
        .cells_y(cells_y_reg),
        .q_count(q_count),
        .ready  (front_ready),
        .q_push (q_push),
        .q_ent  (q_in)
    );

    bgd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .din     (q_in),
        .pop     (q_pop),
        .head    (q_head),
        .nonempty(q_nonempty),
        .count   (q_count)
    );

    bgd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .q_nonempty(q_nonempty),
        .q_pop     (q_pop),
        .res       (res),
        .empty     (empty),
        .pop       (pop),
        .stat      (stat)
    );

endmodule
`default_nettype wire

[rtl/bgd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bgd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[rtl/bgd_front.sv]
// Front end: cell location and bilinear weight computation over two registered stages.
`default_nettype none
module bgd_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         accept,
    input  wire bgd_pkg::bgd_req_t            req,
    input  wire logic [bgd_pkg::CELL_W-1:0]   cells_x,
    input  wire logic [bgd_pkg::CELL_W-1:0]   cells_y,
    input  wire logic [bgd_pkg::QCNT_W-1:0]   q_count,
    output logic                              ready,
    output logic                              q_push,
    output bgd_pkg::bgd_ent_t                 q_ent
);
    import bgd_pkg::*;

    logic              s1_valid_reg, s1_valid_next;
    logic              s2_valid_reg, s2_valid_next;
    logic              s1_op_reg;
    logic [ADDR_W-1:0] s1_node_reg;
    logic [CELL_W-1:0] s1_i_reg, s1_j_reg;
    logic [POS_W-1:0]  s1_fx_reg, s1_fy_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    bgd_ent_t          s2_ent_reg, s2_ent_next;

    logic [CELL_W-1:0] cx, cy, ci, cj;
    logic [POS_W-1:0]  px, py, fx, fy;
    logic [SCL_W-1:0]  sx, sy;
    logic [ROW_W-1:0]  hx, hy;
    logic [POS_W-1:0]  gx, gy;
    logic [PROD_W-1:0] p0, p1, p2, p3;
    logic [2*ROW_W-1:0] jrow;

    // Room is reserved in the queue for every item already in the two stages.
    assign ready = (QCNT_W'(q_count) + QCNT_W'(s1_valid_reg) + QCNT_W'(s2_valid_reg))
                   < QCNT_W'(QDEPTH);

    always_comb
    begin
        cx = eff_cells(cells_x);
        cy = eff_cells(cells_y);
        px = (req.pos_x > ONE_FX) ? ONE_FX : req.pos_x;
        py = (req.pos_y > ONE_FX) ? ONE_FX : req.pos_y;
        sx = SCL_W'(px) * SCL_W'(cx);
        sy = SCL_W'(py) * SCL_W'(cy);
        hx = sx[SCL_W-1:FRAC_BITS];
        hy = sy[SCL_W-1:FRAC_BITS];
        ci = (hx > ROW_W'(cx - 1'b1)) ? (cx - 1'b1) : hx[CELL_W-1:0];
        cj = (hy > ROW_W'(cy - 1'b1)) ? (cy - 1'b1) : hy[CELL_W-1:0];
        fx = POS_W'(sx - (SCL_W'(ci) << FRAC_BITS));
        fy = POS_W'(sy - (SCL_W'(cj) << FRAC_BITS));
    end

    always_comb
    begin
        gx = ONE_FX - s1_fx_reg;
        gy = ONE_FX - s1_fy_reg;
        p0 = PROD_W'(gx) * PROD_W'(gy) + HALF_FX;
        p1 = PROD_W'(s1_fx_reg) * PROD_W'(gy) + HALF_FX;
        p2 = PROD_W'(gx) * PROD_W'(s1_fy_reg) + HALF_FX;
        p3 = PROD_W'(s1_fx_reg) * PROD_W'(s1_fy_reg) + HALF_FX;
        jrow = (2*ROW_W)'(s1_j_reg) * (2*ROW_W)'(s1_row_reg) + (2*ROW_W)'(s1_i_reg);
        s2_ent_next.op         = s1_op_reg;
        s2_ent_next.node_index = s1_node_reg;
        s2_ent_next.row        = s1_row_reg;
        s2_ent_next.base       = jrow[ADDR_W-1:0];
        s2_ent_next.w[0]       = p0[FRAC_BITS +: W_W];
        s2_ent_next.w[1]       = p1[FRAC_BITS +: W_W];
        s2_ent_next.w[2]       = p2[FRAC_BITS +: W_W];
        s2_ent_next.w[3]       = p3[FRAC_BITS +: W_W];
        s1_valid_next = accept;
        s2_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg   <= req.op;
            s1_node_reg <= req.node_index;
            s1_i_reg    <= ci;
            s1_j_reg    <= cj;
            s1_fx_reg   <= fx;
            s1_fy_reg   <= fy;
            s1_row_reg  <= ROW_W'(cx) + 1'b1;
        end
        if (s1_valid_reg)
            s2_ent_reg <= s2_ent_next;
    end

    assign q_push = s2_valid_reg;
    assign q_ent  = s2_ent_reg;

endmodule
`default_nettype wire

[rtl/bgd_queue.sv]
// Short queue of prepared requests between the front end and the back end.
`default_nettype none
module bgd_queue (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    input  wire bgd_pkg::bgd_ent_t           din,
    input  wire logic                        pop,
    output bgd_pkg::bgd_ent_t                head,
    output logic                             nonempty,
    output logic [bgd_pkg::QCNT_W-1:0]       count
);
    import bgd_pkg::*;

    bgd_ent_t          slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= din;
    end

    assign head     = slot_reg[rd_reg];
    assign nonempty = (cnt_reg != '0);
    assign count    = cnt_reg;

endmodule
`default_nettype wire

[rtl/bgd_back.sv]
// Back end: mesh clearing, read-modify-write of the four corners, and node reads.
`default_nettype none
module bgd_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bgd_pkg::bgd_ent_t  head,
    input  wire logic               q_nonempty,
    output logic                    q_pop,
    output bgd_pkg::bgd_res_t       res,
    output logic                    empty,
    input  wire logic               pop,
    output bgd_pkg::bgd_stat_t      stat
);
    import bgd_pkg::*;

    bgd_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [1:0]        corner_reg, corner_next;
    bgd_ent_t          cur_reg;
    logic              out_valid_reg, out_valid_next;
    bgd_res_t          out_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr, corner_addr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;
    logic [ACC_WIDTH:0] sum;
    logic              take_read, take_dep;

    bgd_ram #(
        .WIDTH(WORD_W),
        .DEPTH(NODE_COUNT)
    ) u_mesh (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        case (corner_reg)
            2'd0:    corner_addr = cur_reg.base;
            2'd1:    corner_addr = cur_reg.base + 1'b1;
            2'd2:    corner_addr = cur_reg.base + ADDR_W'(cur_reg.row);
            default: corner_addr = cur_reg.base + ADDR_W'(cur_reg.row) + 1'b1;
        endcase
    end

    assign take_read = (state_reg == B_IDLE) && q_nonempty && (head.op == OP_READ)
                       && !out_valid_reg;
    assign take_dep  = (state_reg == B_IDLE) && q_nonempty && (head.op == OP_DEPOSIT);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_CLEAR:
                if (clr_reg == ADDR_W'(NODE_COUNT - 1))
                    state_next = B_IDLE;
            B_IDLE:
                if (take_read)
                    state_next = B_RDW;
                else if (take_dep)
                    state_next = B_ADDR;
            B_ADDR:
                state_next = B_UPD;
            B_UPD:
                if (corner_reg == 2'd3)
                    state_next = B_IDLE;
                else
                    state_next = B_ADDR;
            B_RDW:
                state_next = B_IDLE;
            default:
                state_next = B_IDLE;
        endcase
    end

    // Outputs and datapath controls
    always_comb
    begin
        sum            = {1'b0, ram_rdata[ACC_WIDTH-1:0]} + (ACC_WIDTH+1)'(cur_reg.w[corner_reg]);
        ram_we         = 1'b0;
        ram_waddr      = corner_addr;
        ram_wdata      = '0;
        ram_raddr      = corner_addr;
        q_pop          = 1'b0;
        clr_next       = clr_reg;
        corner_next    = corner_reg;
        out_valid_next = out_valid_reg && !pop;
        unique case (state_reg)
            B_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
            end
            B_IDLE:
            begin
                ram_raddr   = head.node_index;
                q_pop       = take_read || take_dep;
                corner_next = 2'd0;
            end
            B_ADDR:
            begin
            end
            B_UPD:
            begin
                ram_we = 1'b1;
                if (sum >= {1'b0, ACC_MAX})
                    ram_wdata = {1'b1, ACC_MAX};
                else
                    ram_wdata = {ram_rdata[ACC_WIDTH], sum[ACC_WIDTH-1:0]};
                corner_next = corner_reg + 1'b1;
            end
            B_RDW:
                out_valid_next = 1'b1;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_reg       <= '0;
            corner_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            corner_reg    <= corner_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_dep)
            cur_reg <= head;
        if (state_reg == B_RDW)
        begin
            out_reg.node_value <= OUT_W'(ram_rdata[ACC_WIDTH-1:0]);
            out_reg.saturated  <= ram_rdata[ACC_WIDTH];
        end
    end

    assign res           = out_reg;
    assign empty         = !out_valid_reg;
    assign stat.clearing = (state_reg == B_CLEAR);

endmodule
`default_nettype wire

[bench/testbench.sv]
// Self-checking testbench for the bilinear grid deposit block.
`timescale 1ns / 1ps
module testbench;
    import bgd_pkg::*;

    typedef struct {
        logic             op;
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
        logic [ADDR_W-1:0] node;
        bit               known;
        logic [OUT_W-1:0] value;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = REG_CELLS_X;
    logic [CELL_W-1:0] cfg_data = '0;
    bgd_req_t req = '0;
    logic full;
    logic empty;
    bgd_res_t res;

    // Our own copy of the mesh and the cell counts, updated in request order.
    logic [ACC_WIDTH-1:0] mesh_acc [NODE_COUNT];
    bit                   mesh_sat [NODE_COUNT];
    logic [CELL_W-1:0]    model_cx = 6'd63;
    logic [CELL_W-1:0]    model_cy = 6'd63;

    // Node values that reads have asked for and that have not come back yet.
    bgd_res_t pending_reads[$];
    int mismatches = 0;
    int send_idle = 0;
    int recv_stall = 0;

    bilinear_grid_deposit u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .req(req),
        .empty(empty), .pop(pop), .res(res),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    // The run must end even if the block hangs; the slowest correct run,
    // including the clearing sweep over all 4096 nodes, is far below this.
    initial
    begin
        #15_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // A zero count behaves as one cell; six bits can never exceed the maximum.
    function automatic int active_cells(input logic [CELL_W-1:0] c);
        return (c == 0) ? 1 : int'(c);
    endfunction

    // Cell index along one axis and the Q.16 offset inside that cell.
    task automatic locate_axis(input logic [POS_W-1:0] pos, input int cells,
                               output int cell_idx, output longint off);
        longint p;
        longint scaled;
        p = (pos > ONE_FX) ? longint'(ONE_FX) : longint'(pos);
        scaled = p * cells;
        cell_idx = int'(scaled >> FRAC_BITS);
        if (cell_idx > cells - 1)
            cell_idx = cells - 1;
        off = scaled - (longint'(cell_idx) << FRAC_BITS);
    endtask

    // Add one rounded bilinear weight to a node, saturating at the top.
    task automatic add_weight(input int idx, input longint a, input longint b);
        longint w;
        longint room;
        w = (a * b + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (idx >= NODE_COUNT)
            return;
        room = longint'(ACC_MAX) - longint'(mesh_acc[idx]);
        if (w >= room)
        begin
            mesh_acc[idx] = ACC_MAX;
            mesh_sat[idx] = 1'b1;
        end
        else
            mesh_acc[idx] = mesh_acc[idx] + ACC_WIDTH'(w);
    endtask

    task automatic deposit_point(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py);
        int cx;
        int cy;
        int i;
        int j;
        int base;
        longint fx;
        longint fy;
        longint one;
        cx = active_cells(model_cx);
        cy = active_cells(model_cy);
        one = longint'(ONE_FX);
        locate_axis(px, cx, i, fx);
        locate_axis(py, cy, j, fy);
        base = j * (cx + 1) + i;
        add_weight(base,          one - fx, one - fy);
        add_weight(base + 1,      fx,       one - fy);
        add_weight(base + cx + 1, one - fx, fy);
        add_weight(base + cx + 2, fx,       fy);
    endtask

    // Offer one request and wait until the block takes it. Push is only
    // lowered when an idle gap is taken, so it never drops and rises in one step.
    task automatic send_request(input bgd_req_t r);
        if ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle)
                @(posedge clk);
        end
        push <= 1'b1;
        req  <= r;
        @(negedge clk);
        while (full)
        begin
            @(posedge clk);
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    // Accepted request: advance the predictor; a read queues its answer.
    task automatic commit_request(input bgd_req_t r, input bit known,
                                  input logic [OUT_W-1:0] value);
        bgd_res_t e;
        if (r.op == OP_READ)
        begin
            e.node_value = known ? value : OUT_W'(mesh_acc[r.node_index]);
            e.saturated  = known ? 1'b0 : mesh_sat[r.node_index];
            pending_reads.push_back(e);
        end
        else
            deposit_point(r.pos_x, r.pos_y);
    endtask

    // Wait until every read has been answered, then let queued deposits finish
    // in the back end (up to four queued, plus the front end).
    task automatic drain_block();
        push <= 1'b0;
        @(posedge clk);
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CELL_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_CELLS_X)
            model_cx = val;
        else
            model_cy = val;
    endtask

    // Coordinates weighted toward the corners, out-of-range values and cell
    // boundaries, where the floor and the clamp to the last cell matter.
    function automatic logic [POS_W-1:0] pick_pos(input int cells);
        int k;
        longint b;
        case ($urandom_range(9))
            0: return '0;
            1: return ONE_FX;
            2: return POS_W'($urandom_range(131071, 65537));
            3, 4:
            begin
                k = $urandom_range(cells);
                b = (longint'(k) << FRAC_BITS) / cells;
                b = b + $urandom_range(2) - 1;
                if (b < 0)
                    b = 0;
                return POS_W'(b);
            end
            default: return POS_W'($urandom_range(65536));
        endcase
    endfunction

    function automatic bgd_req_t random_request();
        bgd_req_t r;
        int cx;
        int cy;
        cx = active_cells(model_cx);
        cy = active_cells(model_cy);
        r.op = ($urandom_range(99) < 40) ? OP_READ : OP_DEPOSIT;
        r.pos_x = pick_pos(cx);
        r.pos_y = pick_pos(cy);
        // Most reads land in the active mesh; the rest hit any stored word.
        if ($urandom_range(99) < 70)
            r.node_index = ADDR_W'($urandom_range(cy) * (cx + 1) + $urandom_range(cx));
        else
            r.node_index = ADDR_W'($urandom_range(NODE_COUNT - 1));
        return r;
    endfunction

    // The receiver decides every cycle whether to take a result.
    always @(posedge clk)
        pop <= ($urandom_range(99) >= recv_stall);

    // Outputs are stable at the falling edge; a result counts as taken when
    // pop is high with empty low, at the rising edge that follows.
    always @(negedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_reads.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value=%0d sat=%0b", res.node_value,
                             res.saturated);
            end
            else if (res !== pending_reads[0])
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected value=%0d sat=%0b, got value=%0d sat=%0b",
                             pending_reads[0].node_value, pending_reads[0].saturated,
                             res.node_value, res.saturated);
                void'(pending_reads.pop_front());
            end
            else
                void'(pending_reads.pop_front());
        end
    end

    stim_row_t directed[$];
    int cfg_x_list[8] = '{63, 1, 0, 63, 1, 7, 32, 63};
    int cfg_y_list[8] = '{63, 1, 0, 1, 63, 5, 17, 63};
    int idle_list[4]  = '{0, 69, 0, 26};
    int stall_list[4] = '{0, 0, 69, 26};

    initial
    begin
        bgd_req_t r;
        for (int n = 0; n < NODE_COUNT; n++)
        begin
            mesh_acc[n] = '0;
            mesh_sat[n] = 1'b0;
        end
        // Directed rows with the default 63 by 63 mesh: corners, coordinates
        // above one, the last-cell clamp and the exact cell centre.
        directed = '{
            '{OP_READ,    17'd0,      17'd0,      12'd0,    1, 40'd0},
            '{OP_READ,    17'd0,      17'd0,      12'd4095, 1, 40'd0},
            '{OP_DEPOSIT, 17'd0,      17'd0,      12'd4095, 0, 40'd0},
            '{OP_READ,    17'd0,      17'd0,      12'd0,    1, 40'd65536},
            '{OP_DEPOSIT, 17'd65536,  17'd65536,  12'd0,    0, 40'd0},
            '{OP_READ,    17'd0,      17'd0,      12'd4095, 1, 40'd65536},
            '{OP_DEPOSIT, 17'h1FFFF,  17'h1FFFF,  12'd0,    0, 40'd0},
            '{OP_READ,    17'd0,      17'd0,      12'd4095, 1, 40'd131072},
            '{OP_DEPOSIT, 17'h1FFFF,  17'd0,      12'd0,    0, 40'd0},
            '{OP_READ,    17'd0,      17'd0,      12'd63,   1, 40'd65536},
            '{OP_DEPOSIT, 17'd32768,  17'd32768,  12'd0,    0, 40'd0},
            '{OP_READ,    17'h1FFFF,  17'h1FFFF,  12'd2080, 1, 40'd16384},
            '{OP_DEPOSIT, 17'd1000,   17'd60000,  12'hFFF,  0, 40'd0},
            '{OP_READ,    17'd0,      17'd0,      12'd2016, 0, 40'd0},
            '{OP_READ,    17'd0,      17'd0,      12'd3000, 0, 40'd0}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // The first request waits out the clearing sweep through full.
        foreach (directed[k])
        begin
            r.op         = directed[k].op;
            r.pos_x      = directed[k].px;
            r.pos_y      = directed[k].py;
            r.node_index = directed[k].node;
            send_request(r);
            commit_request(r, directed[k].known, directed[k].value);
        end

        // Random phases: each starts idle, sets new cell counts (the mesh keeps
        // its contents and is re-indexed) and picks an idling pattern.
        for (int ph = 0; ph < 8; ph++)
        begin
            drain_block();
            write_reg(REG_CELLS_X, CELL_W'(cfg_x_list[ph]));
            write_reg(REG_CELLS_Y, CELL_W'(cfg_y_list[ph]));
            send_idle  = idle_list[ph % 4];
            recv_stall = stall_list[ph % 4];
            for (int n = 0; n < 160; n++)
            begin
                r = random_request();
                send_request(r);
                commit_request(r, 1'b0, '0);
            end
        end

        send_idle = 0;
        recv_stall = 0;
        drain_block();
        if (mismatches == 0 && pending_reads.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

[files.f]
rtl/bgd_pkg.sv
rtl/bgd_ram.sv
rtl/bgd_front.sv
rtl/bgd_queue.sv
rtl/bgd_back.sv
rtl/bilinear_grid_deposit.sv
bench/testbench.sv
